FILE: rtl/arpc_pkg.sv
// Package for the ARP responder: packet and result types, codes and header constants.
`default_nettype none

package arpc_pkg;

   // Header fields of one received ARP packet.
   typedef struct packed {
      logic [15:0] hw_type;
      logic [15:0] proto_type;
      logic [7:0]  hw_len;
      logic [7:0]  proto_len;
      logic [15:0] arp_op;
      logic [31:0] sender_ip;
      logic [47:0] sender_mac;
      logic [31:0] target_ip;
   } arpc_req_type;

   // Outcome of one packet plus the reply header fields.
   typedef struct packed {
      logic [1:0]  status;
      logic        cache_hit;
      logic        cache_inserted;
      logic [15:0] reply_op;
      logic [31:0] reply_sender_ip;
      logic [47:0] reply_sender_mac;
      logic [31:0] reply_target_ip;
      logic [47:0] reply_target_mac;
   } arpc_rsp_type;

   // One cache entry as kept in the cache memory.
   typedef struct packed {
      logic [31:0] ip;
      logic [47:0] mac;
   } arpc_entry_type;

   // Register indexes on the CSR channel.
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_IP  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_MAC = 1'b1;
   localparam int unsigned CSR_DATA_W = 48;

   // Result status codes.
   localparam logic [1:0] STATUS_MALFORMED  = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOR_US = 2'd1;
   localparam logic [1:0] STATUS_ACCEPTED   = 2'd2;
   localparam logic [1:0] STATUS_REPLIED    = 2'd3;

   // Header values that a well-formed Ethernet/IPv4 ARP packet carries.
   localparam logic [15:0] HW_TYPE_ETHERNET = 16'h0001;
   localparam logic [15:0] PROTO_TYPE_IPV4  = 16'h0800;
   localparam logic [7:0]  HW_LEN_ETHERNET  = 8'd6;
   localparam logic [7:0]  PROTO_LEN_IPV4   = 8'd4;

   // ARP operation codes.
   localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
   localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

endpackage

`default_nettype wire

FILE: rtl/arp_responder_with_cache.sv
// ARP responder with an ARP cache kept in a synchronous memory.
//
//  channel  | ports                              | transfer when
//  ---------+------------------------------------+----------------------------
//  request  | start, busy, req_data              | start high and busy low
//  result   | rsp_valid, rsp_data                | every cycle rsp_valid is high
//  csr      | csr_valid, csr_ready, csr_index,   | csr_valid and csr_ready high
//           | csr_wdata                          |
//
// A malformed packet gives its result in the cycle after the transfer.
// A well-formed packet scans the cache memory one entry per cycle through the
// registered read port, stops at the first match, then passes through the
// cache update state, where the result is registered; the linear scan of the
// cache memory sets when the result shows.
// Reset (synchronous) clears all valid bits, the replace pointer and the own
// address registers at once; no clearing pass. The receiver cannot stall:
// each result is a one-cycle strobe. csr_ready is always high.
`default_nettype none

module arp_responder_with_cache
   import arpc_pkg::*;
#(
   parameter int unsigned CACHE_DEPTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request
   input  wire logic                   start,
   output logic                        busy,
   input  wire arpc_req_type           req_data,
   // result
   output logic                        rsp_valid,
   output arpc_rsp_type                rsp_data,
   // configuration
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
   localparam int unsigned CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(CACHE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CACHE_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   // control state
   state_type              state_ff, state_in;
   logic [CACHE_DEPTH-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]       ptr_ff, ptr_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   hit_ff, hit_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            own_ip_ff, own_ip_in;
   logic [47:0]            own_mac_ff, own_mac_in;

   // payload
   arpc_req_type           req_ff, req_in;
   arpc_rsp_type           rsp_data_ff, rsp_data_in;

   // cache memory and its ports
   arpc_entry_type         cache_mem [CACHE_DEPTH];
   arpc_entry_type         rd_entry_ff;
   logic                   rd_en;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   arpc_entry_type         mem_wdata;

   logic                   accept;
   logic                   header_ok;
   logic                   for_us;
   logic                   is_request;
   logic                   do_insert;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign header_ok = (req_data.hw_type == HW_TYPE_ETHERNET) &&
                      (req_data.proto_type == PROTO_TYPE_IPV4) &&
                      (req_data.hw_len == HW_LEN_ETHERNET) &&
                      (req_data.proto_len == PROTO_LEN_IPV4);

   assign for_us     = (req_ff.target_ip == own_ip_ff);
   assign is_request = (req_ff.arp_op == ARP_OP_REQUEST);
   assign do_insert  = for_us && !hit_ff;

   // configuration writes
   always_comb begin
      own_ip_in  = own_ip_ff;
      own_mac_in = own_mac_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OWN_IP:  own_ip_in  = csr_wdata[31:0];
            CSR_OWN_MAC: own_mac_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // main sequencer: accept, scan, update
   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = cnt_ff[IDX_W-1:0];
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      req_in        = req_ff;
      rd_en         = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = hit_idx_ff;
      mem_wdata     = {req_ff.sender_ip, req_ff.sender_mac};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               if (header_ok) begin
                  state_in      = ST_SCAN;
                  cnt_in        = '0;
                  hit_in        = 1'b0;
                  free_found_in = 1'b0;
               end else begin
                  // malformed: answer at once, cache untouched
                  rsp_valid_in       = 1'b1;
                  rsp_data_in        = '0;
                  rsp_data_in.status = STATUS_MALFORMED;
               end
            end
         end

         ST_SCAN: begin
            // issue one read per cycle
            if (cnt_ff != DEPTH_CNT) begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               cnt_in     = cnt_ff + 1'b1;
            end
            // compare the entry read last cycle
            if (rd_pend_ff) begin
               if (valid_ff[rd_idx_ff] && (rd_entry_ff.ip == req_ff.sender_ip)) begin
                  hit_in     = 1'b1;
                  hit_idx_in = rd_idx_ff;
                  state_in   = ST_UPDATE;
               end else begin
                  if (!valid_ff[rd_idx_ff] && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = rd_idx_ff;
                  end
                  if (rd_idx_ff == LAST_IDX) begin
                     state_in = ST_UPDATE;
                  end
               end
            end
         end

         ST_UPDATE: begin
            state_in = ST_IDLE;
            // refresh on hit, else insert when addressed to us
            if (hit_ff) begin
               mem_we    = 1'b1;
               mem_waddr = hit_idx_ff;
            end else if (for_us) begin
               mem_we = 1'b1;
               if (free_found_ff) begin
                  mem_waddr = free_idx_ff;
               end else begin
                  mem_waddr = ptr_ff;
                  ptr_in    = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
               end
               valid_in[mem_waddr] = 1'b1;
            end

            rsp_valid_in               = 1'b1;
            rsp_data_in                = '0;
            rsp_data_in.cache_hit      = hit_ff;
            rsp_data_in.cache_inserted = do_insert;
            if (!for_us) begin
               rsp_data_in.status = STATUS_NOT_FOR_US;
            end else if (is_request) begin
               rsp_data_in.status           = STATUS_REPLIED;
               rsp_data_in.reply_op         = ARP_OP_REPLY;
               rsp_data_in.reply_sender_ip  = own_ip_ff;
               rsp_data_in.reply_sender_mac = own_mac_ff;
               rsp_data_in.reply_target_ip  = req_ff.sender_ip;
               rsp_data_in.reply_target_mac = req_ff.sender_mac;
            end else begin
               rsp_data_in.status = STATUS_ACCEPTED;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         ptr_ff        <= '0;
         cnt_ff        <= '0;
         rd_pend_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         own_ip_ff     <= '0;
         own_mac_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         ptr_ff        <= ptr_in;
         cnt_ff        <= cnt_in;
         rd_pend_ff    <= rd_pend_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
         own_ip_ff     <= own_ip_in;
         own_mac_ff    <= own_mac_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
      rd_idx_ff   <= rd_idx_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
   end

   // cache memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cache_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= cache_mem[cnt_ff[IDX_W-1:0]];
      end
   end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the ARP responder with its ARP cache.
`timescale 1ns / 100ps

module tb;
   import arpc_pkg::*;

   localparam int unsigned CACHE_DEPTH = 16;
   localparam int          PHASES      = 6;
   localparam int          PHASE_ITEMS = 242;
   localparam int          POOL_SIZE   = 20;   // more IPs than entries forces replacement
   localparam int          SETTLE      = 25;   // margin that outlasts the longest cache scan
   localparam int          DRAIN_LIMIT = 4000;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   arpc_req_type           req_data;
   logic                   rsp_valid;
   arpc_rsp_type           rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   arp_responder_with_cache #(
      .CACHE_DEPTH(CACHE_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Free-running clock, 2 ns period.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #1_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // Cache and register image kept by the testbench
   // ------------------------------------------------------------------
   logic        cache_valid [CACHE_DEPTH];
   logic [31:0] cache_ip    [CACHE_DEPTH];
   logic [47:0] cache_mac   [CACHE_DEPTH];
   int          victim_ptr;
   logic [31:0] cfg_ip;
   logic [47:0] cfg_mac;

   // Results owed by the block, oldest first.
   arpc_rsp_type pending_rsp[$];

   int errors;
   int packets_sent;
   int results_seen;
   int status_count [4];
   int hit_count;
   int insert_count;
   int evict_count;

   // Works out the result of one packet and applies its cache update.
   function automatic arpc_rsp_type resolve_arp(arpc_req_type p);
      arpc_rsp_type r;
      int hit_at;
      int slot;
      r = '0;
      hit_at = -1;
      slot = -1;
      // Bad header: dropped, cache untouched.
      if (p.hw_type != HW_TYPE_ETHERNET || p.hw_len != HW_LEN_ETHERNET ||
          p.proto_type != PROTO_TYPE_IPV4 || p.proto_len != PROTO_LEN_IPV4) begin
         r.status = STATUS_MALFORMED;
         return r;
      end
      // Only valid entries match; the lowest index wins.
      for (int i = 0; i < CACHE_DEPTH; i++) begin
         if (hit_at < 0 && cache_valid[i] && cache_ip[i] == p.sender_ip) begin
            hit_at = i;
         end
      end
      // A refresh happens even when the packet is not for us.
      if (hit_at >= 0) begin
         cache_mac[hit_at] = p.sender_mac;
         r.cache_hit = 1'b1;
      end
      if (p.target_ip != cfg_ip) begin
         r.status = STATUS_NOT_FOR_US;
         return r;
      end
      if (hit_at < 0) begin
         // First free entry, else round robin; the pointer only moves on a replacement.
         for (int i = 0; i < CACHE_DEPTH; i++) begin
            if (slot < 0 && !cache_valid[i]) begin
               slot = i;
            end
         end
         if (slot < 0) begin
            slot = victim_ptr;
            victim_ptr = (victim_ptr + 1) % CACHE_DEPTH;
            evict_count++;
         end
         cache_valid[slot] = 1'b1;
         cache_ip[slot] = p.sender_ip;
         cache_mac[slot] = p.sender_mac;
         r.cache_inserted = 1'b1;
      end
      if (p.arp_op == ARP_OP_REQUEST) begin
         r.status = STATUS_REPLIED;
         r.reply_op = ARP_OP_REPLY;
         r.reply_sender_ip = cfg_ip;
         r.reply_sender_mac = cfg_mac;
         r.reply_target_ip = p.sender_ip;
         r.reply_target_mac = p.sender_mac;
      end else begin
         r.status = STATUS_ACCEPTED;
      end
      return r;
   endfunction

   function automatic arpc_req_type arp_packet(logic [15:0] hw_type, logic [15:0] proto_type,
                                               logic [7:0] hw_len, logic [7:0] proto_len,
                                               logic [15:0] arp_op, logic [31:0] sender_ip,
                                               logic [47:0] sender_mac,
                                               logic [31:0] target_ip);
      arpc_req_type p;
      p.hw_type = hw_type;
      p.proto_type = proto_type;
      p.hw_len = hw_len;
      p.proto_len = proto_len;
      p.arp_op = arp_op;
      p.sender_ip = sender_ip;
      p.sender_mac = sender_mac;
      p.target_ip = target_ip;
      return p;
   endfunction

   // Well-formed Ethernet/IPv4 header with the given body.
   function automatic arpc_req_type eth_ipv4_packet(logic [15:0] arp_op, logic [31:0] sender_ip,
                                                    logic [47:0] sender_mac,
                                                    logic [31:0] target_ip);
      return arp_packet(HW_TYPE_ETHERNET, PROTO_TYPE_IPV4, HW_LEN_ETHERNET, PROTO_LEN_IPV4,
                        arp_op, sender_ip, sender_mac, target_ip);
   endfunction

   function automatic logic [47:0] rand_mac();
      return 48'({$urandom(), $urandom()});
   endfunction

   task automatic report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
   endtask

   // ------------------------------------------------------------------
   // Result checker: every strobe is a transfer, compared with the oldest
   // expectation field by field.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      arpc_rsp_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         results_seen++;
         if (pending_rsp.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected", results_seen));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status)
               report($sformatf("result %0d status %0d, want %0d",
                                results_seen, rsp_data.status, want.status));
            if (rsp_data.cache_hit !== want.cache_hit)
               report($sformatf("result %0d cache_hit %b, want %b",
                                results_seen, rsp_data.cache_hit, want.cache_hit));
            if (rsp_data.cache_inserted !== want.cache_inserted)
               report($sformatf("result %0d cache_inserted %b, want %b",
                                results_seen, rsp_data.cache_inserted, want.cache_inserted));
            if (rsp_data.reply_op !== want.reply_op)
               report($sformatf("result %0d reply_op %h, want %h",
                                results_seen, rsp_data.reply_op, want.reply_op));
            if (rsp_data.reply_sender_ip !== want.reply_sender_ip)
               report($sformatf("result %0d reply_sender_ip %h, want %h",
                                results_seen, rsp_data.reply_sender_ip,
                                want.reply_sender_ip));
            if (rsp_data.reply_sender_mac !== want.reply_sender_mac)
               report($sformatf("result %0d reply_sender_mac %h, want %h",
                                results_seen, rsp_data.reply_sender_mac,
                                want.reply_sender_mac));
            if (rsp_data.reply_target_ip !== want.reply_target_ip)
               report($sformatf("result %0d reply_target_ip %h, want %h",
                                results_seen, rsp_data.reply_target_ip,
                                want.reply_target_ip));
            if (rsp_data.reply_target_mac !== want.reply_target_mac)
               report($sformatf("result %0d reply_target_mac %h, want %h",
                                results_seen, rsp_data.reply_target_mac,
                                want.reply_target_mac));
            status_count[want.status]++;
            hit_count += want.cache_hit;
            insert_count += want.cache_inserted;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // Drives one packet from the falling edge and holds it until a transfer.
   // A typed result, when given, stands in for the predicted one; the
   // predictor still runs so the cache image stays in step.
   task automatic send_packet(arpc_req_type pkt, bit typed, arpc_rsp_type typed_rsp);
      arpc_rsp_type predicted;
      @(negedge clock);
      start <= 1'b1;
      req_data <= pkt;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = resolve_arp(pkt);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      packets_sent++;
   endtask

   // Sender gap with start low; its length comes from n.
   task automatic idle_for(int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Stop sending and wait out every owed result plus the longest scan.
   task automatic drain();
      int guard;
      guard = 0;
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] wdata);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_OWN_IP) begin
         cfg_ip = wdata[31:0];
      end else begin
         cfg_mac = wdata;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Directed table row.
   typedef struct {
      bit           reconfig;   // drain and set both addresses to all ones first
      arpc_req_type pkt;
      bit           typed;
      arpc_rsp_type rsp;
   } stim_row_type;

   stim_row_type directed_rows[$];

   function automatic void add_row(bit reconfig, arpc_req_type pkt, bit typed,
                                   arpc_rsp_type rsp);
      stim_row_type row;
      row.reconfig = reconfig;
      row.pkt = pkt;
      row.typed = typed;
      row.rsp = rsp;
      directed_rows.push_back(row);
   endfunction

   initial begin
      logic [31:0]  ip_pool [POOL_SIZE];
      arpc_req_type pkt;
      int           pick;
      int           field;
      logic [31:0]  new_ip;
      logic [47:0]  new_mac;
      logic [31:0]  ones32;
      logic [47:0]  ones48;

      ones32 = '1;
      ones48 = '1;
      errors = 0;
      packets_sent = 0;
      results_seen = 0;
      hit_count = 0;
      insert_count = 0;
      evict_count = 0;
      for (int s = 0; s < 4; s++) status_count[s] = 0;

      // Cache image after reset.
      for (int i = 0; i < CACHE_DEPTH; i++) begin
         cache_valid[i] = 1'b0;
         cache_ip[i] = '0;
         cache_mac[i] = '0;
      end
      victim_ptr = 0;
      cfg_ip = '0;
      cfg_mac = '0;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_OWN_IP;
      csr_wdata = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // --- Directed table --------------------------------------------
      // Both addresses are zero after reset. Every header check failing on
      // its own, at both extremes: dropped with an all-zero result.
      add_row(0, arp_packet(16'h0000, PROTO_TYPE_IPV4, HW_LEN_ETHERNET, PROTO_LEN_IPV4,
                            ARP_OP_REQUEST, 32'h0, 48'h0, 32'h0), 1, '0);
      add_row(0, arp_packet(16'hFFFF, PROTO_TYPE_IPV4, HW_LEN_ETHERNET, PROTO_LEN_IPV4,
                            ARP_OP_REQUEST, 32'h0, 48'h0, 32'h0), 1, '0);
      add_row(0, arp_packet(HW_TYPE_ETHERNET, 16'h0000, HW_LEN_ETHERNET, PROTO_LEN_IPV4,
                            ARP_OP_REQUEST, 32'h0, 48'h0, 32'h0), 1, '0);
      add_row(0, arp_packet(HW_TYPE_ETHERNET, 16'hFFFF, HW_LEN_ETHERNET, PROTO_LEN_IPV4,
                            ARP_OP_REQUEST, 32'h0, 48'h0, 32'h0), 1, '0);
      add_row(0, arp_packet(HW_TYPE_ETHERNET, PROTO_TYPE_IPV4, 8'h00, PROTO_LEN_IPV4,
                            ARP_OP_REQUEST, 32'h0, 48'h0, 32'h0), 1, '0);
      add_row(0, arp_packet(HW_TYPE_ETHERNET, PROTO_TYPE_IPV4, 8'hFF, PROTO_LEN_IPV4,
                            ARP_OP_REQUEST, ones32, ones48, ones32), 1, '0);
      add_row(0, arp_packet(HW_TYPE_ETHERNET, PROTO_TYPE_IPV4, HW_LEN_ETHERNET, 8'h00,
                            ARP_OP_REQUEST, 32'h0, 48'h0, 32'h0), 1, '0);
      add_row(0, arp_packet(HW_TYPE_ETHERNET, PROTO_TYPE_IPV4, HW_LEN_ETHERNET, 8'hFF,
                            16'hFFFF, ones32, ones48, ones32), 1, '0);
      // Request for own IP zero from an all-ones sender: inserted, reply out.
      add_row(0, eth_ipv4_packet(ARP_OP_REQUEST, ones32, ones48, 32'h0), 1,
              arpc_rsp_type'({STATUS_REPLIED, 1'b0, 1'b1, ARP_OP_REPLY, 32'h0, 48'h0,
                              ones32, ones48}));
      // Not for us, unknown sender: nothing but the status.
      add_row(0, eth_ipv4_packet(ARP_OP_REQUEST, 32'h0, 48'h0, ones32), 1,
              arpc_rsp_type'({STATUS_NOT_FOR_US, 178'b0}));
      // Addresses at all ones from here; these rows go to the predictor.
      // Known sender refreshed, reply from own addresses.
      add_row(1, eth_ipv4_packet(ARP_OP_REQUEST, ones32, 48'h0000_0000_0001, ones32), 0, '0);
      // Reply and odd opcodes: accepted without reply, new senders inserted.
      add_row(0, eth_ipv4_packet(ARP_OP_REPLY, 32'h0A00_0001, 48'h02AA_BBCC_DD01, ones32),
              0, '0);
      add_row(0, eth_ipv4_packet(16'h0000, 32'h0A00_0002, 48'h02AA_BBCC_DD02, ones32), 0, '0);
      add_row(0, eth_ipv4_packet(16'hFFFF, 32'h0A00_0001, 48'h0, ones32), 0, '0);
      // Not for us yet the sender is cached: refresh still counts as a hit.
      add_row(0, eth_ipv4_packet(ARP_OP_REQUEST, ones32, 48'h1234_5678_9ABC, 32'h0), 0, '0);
      // Bad header from a cached sender leaves the entry alone.
      add_row(0, arp_packet(HW_TYPE_ETHERNET, 16'h0806, HW_LEN_ETHERNET, PROTO_LEN_IPV4,
                            ARP_OP_REQUEST, 32'h0A00_0002, 48'h0, ones32), 0, '0);
      add_row(0, eth_ipv4_packet(ARP_OP_REQUEST, 32'h0, 48'hFFFF_0000_FFFF, ones32), 0, '0);
      add_row(0, eth_ipv4_packet(ARP_OP_REQUEST, 32'h0A00_0002, 48'h0000_FFFF_0000, ones32),
              0, '0);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].reconfig) begin
            drain();
            // Upper data bits set on the IP write: only the low 32 count.
            csr_write(CSR_OWN_IP, ones48);
            csr_write(CSR_OWN_MAC, ones48);
         end
         send_packet(directed_rows[r].pkt, directed_rows[r].typed, directed_rows[r].rsp);
         if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 4));
      end

      // --- Random phases ---------------------------------------------
      // Each phase drains, reprograms both addresses, then sends mostly
      // well-formed traffic around a small IP pool so hits, inserts and
      // round-robin replacement all happen. The last phase has no gaps.
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: begin
               new_ip = '0;
               new_mac = '0;
            end
            1: begin
               new_ip = ones32;
               new_mac = ones48;
            end
            default: begin
               new_ip = $urandom();
               new_mac = rand_mac();
            end
         endcase
         if ($urandom_range(0, 1) == 0) begin
            csr_write(CSR_OWN_MAC, new_mac);
            csr_write(CSR_OWN_IP, {16'($urandom()), new_ip});
         end else begin
            csr_write(CSR_OWN_IP, {16'($urandom()), new_ip});
            csr_write(CSR_OWN_MAC, new_mac);
         end
         for (int i = 0; i < POOL_SIZE; i++) ip_pool[i] = $urandom();

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               // pure noise
               pkt = arpc_req_type'(176'({$urandom(), $urandom(), $urandom(), $urandom(),
                                          $urandom(), $urandom()}));
            end else begin
               pkt = eth_ipv4_packet(ARP_OP_REQUEST, ip_pool[$urandom_range(0, POOL_SIZE-1)],
                                     rand_mac(), cfg_ip);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: pkt.arp_op = ARP_OP_REQUEST;
                  5, 6:          pkt.arp_op = ARP_OP_REPLY;
                  default:       pkt.arp_op = 16'($urandom());
               endcase
               case ($urandom_range(0, 19))
                  0:       pkt.sender_ip = $urandom();
                  1:       pkt.sender_ip = cfg_ip;
                  default: ;
               endcase
               case ($urandom_range(0, 9))
                  0, 1, 2: pkt.target_ip = ip_pool[$urandom_range(0, POOL_SIZE-1)];
                  3:       pkt.target_ip = $urandom();
                  default: ;
               endcase
               if (pick < 16) begin
                  // broken header, one field at a time
                  field = $urandom_range(0, 3);
                  case (field)
                     0:       pkt.hw_type = 16'($urandom());
                     1:       pkt.proto_type = 16'($urandom());
                     2:       pkt.hw_len = 8'($urandom());
                     default: pkt.proto_len = 8'($urandom());
                  endcase
               end
            end
            send_packet(pkt, 0, '0);
            if (ph != PHASES - 1 && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 4));
         end
      end

      // --- End of run -------------------------------------------------
      drain();
      if (pending_rsp.size() != 0) begin
         report($sformatf("%0d expected results never arrived", pending_rsp.size()));
      end

      $display("Covered %0d packets / %0d results: %0d dropped, %0d not for us, %0d accepted,",
               packets_sent, results_seen, status_count[STATUS_MALFORMED],
               status_count[STATUS_NOT_FOR_US], status_count[STATUS_ACCEPTED]);
      $display("  %0d replies, %0d cache hits, %0d inserts (%0d round-robin), %0d mismatches",
               status_count[STATUS_REPLIED], hit_count, insert_count, evict_count, errors);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
